>>> design/float_sum_max_reduction_top_macros.svh
// Assertion macros shared by the checker.
`ifndef FLOAT_SUM_MAX_REDUCTION_TOP_MACROS_SVH
`define FLOAT_SUM_MAX_REDUCTION_TOP_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define FSMR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define FSMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/fsmr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fsmr_pkg;

  localparam int unsigned DataW = 32;
  localparam logic [DataW-1:0] F32PosZero = 32'h0000_0000;
  localparam logic [DataW-1:0] F32NegInf  = 32'hFF80_0000;
  localparam logic [DataW-1:0] F32DefNan  = 32'hFFC0_0000;

  typedef enum logic [0:0] {
    ModeSum = 1'b0,
    ModeMax = 1'b1
  } mode_e;

  localparam logic [0:0] RegReduceMode = 1'b0;

  function automatic logic is_nan(input logic [31:0] v);
    return v[30:23] == 8'hFF && v[22:0] != 23'd0;
  endfunction

  function automatic logic [31:0] identity_for(input mode_e m);
    return (m == ModeMax) ? F32NegInf : F32PosZero;
  endfunction

  function automatic logic [31:0] order_key(input logic [31:0] v);
    return v[31] ? ~v : (v | 32'h8000_0000);
  endfunction

  function automatic logic f32_greater(input logic [31:0] a, input logic [31:0] b);
    logic r;
    r = 1'b0;
    if (is_nan(a) || is_nan(b)) r = 1'b0;
    else if (a[30:0] == 31'd0 && b[30:0] == 31'd0) r = 1'b0;
    else r = order_key(a) > order_key(b);
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/fsmr_add.sv
`timescale 1ns / 1ps
`default_nettype none
// Combinational binary32 adder, round to nearest even, gradual underflow.
module fsmr_add import fsmr_pkg::*; (
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [31:0] sum_o
);

  logic        swap;
  logic [31:0] big, sml;
  logic [7:0]  xa, xb, dexp;
  logic [30:0] sa, sb, sb_sh, lost_mask;
  logic [31:0] s, sn;
  logic [4:0]  lz;
  logic [9:0]  e;
  logic [6:0]  rem;
  logic [24:0] m;
  logic        special;
  logic [31:0] special_val;

  always_comb begin
    special = 1'b1;
    special_val = F32PosZero;
    if (is_nan(a_i)) special_val = a_i | 32'h0040_0000;
    else if (is_nan(b_i)) special_val = b_i | 32'h0040_0000;
    else if (a_i[30:23] == 8'hFF) begin
      special_val = (b_i[30:23] == 8'hFF && (a_i[31] ^ b_i[31])) ? F32DefNan : a_i;
    end else if (b_i[30:23] == 8'hFF) special_val = b_i;
    else if (a_i[30:0] == 31'd0 && b_i[30:0] == 31'd0) special_val = a_i & b_i;
    else special = 1'b0;
  end

  always_comb begin
    swap = b_i[30:0] > a_i[30:0];
    big  = swap ? b_i : a_i;
    sml  = swap ? a_i : b_i;
    xa   = (big[30:23] != 8'd0) ? big[30:23] : 8'd1;
    xb   = (sml[30:23] != 8'd0) ? sml[30:23] : 8'd1;
    sa   = {big[30:23] != 8'd0, big[22:0], 7'd0};
    sb   = {sml[30:23] != 8'd0, sml[22:0], 7'd0};
    dexp = xa - xb;
    lost_mask = ~(31'h7FFF_FFFF << dexp[4:0]);
    if (dexp > 8'd30) begin
      sb_sh = {30'd0, sb != 31'd0};
    end else begin
      sb_sh = (sb >> dexp[4:0]) | {30'd0, (sb & lost_mask) != 31'd0};
    end
    s = (big[31] == sml[31]) ? ({1'b0, sa} + {1'b0, sb_sh}) : ({1'b0, sa} - {1'b0, sb_sh});
    e = {2'b00, xa};
    sn = s;
    if (s[31]) begin
      sn = {1'b0, s[31:2], s[1] | s[0]};
      e = e + 10'd1;
    end
    // Leading zero count below bit 30, capped so the exponent stays at least 1.
    lz = 5'd0;
    for (int i = 30; i >= 0; i--) begin
      if (sn[i] == 1'b0 && lz == 5'(30 - i)) lz = 5'(30 - i + 1);
    end
    if ({5'd0, lz} > e - 10'd1) lz = 5'(e - 10'd1);
    sn = sn << lz;
    e = e - {5'd0, lz};
    rem = sn[6:0];
    m = {1'b0, sn[30:7]};
    if (rem > 7'h40 || (rem == 7'h40 && m[0])) m = m + 25'd1;
    if (m[24]) begin
      m = m >> 1;
      e = e + 10'd1;
    end
    if (special) sum_o = special_val;
    else if (s == 32'd0) sum_o = F32PosZero;
    else if (e >= 10'd255) sum_o = {big[31], 31'h7F80_0000};
    else if (!m[23]) sum_o = {big[31], 8'd0, m[22:0]};
    else sum_o = {big[31], e[7:0], m[22:0]};
  end

endmodule
`default_nettype wire

>>> design/float_sum_max_reduction_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Streaming binary32 sum or maximum reduction. One item enters per cycle
// unless held off; the accumulator register feeds the combinational adder
// or comparator. A vector's result enters the output register with its last
// item, or the skid register behind it if that is stalled. It takes one more
// result, so the input is held off only while both hold results, and ready_i
// never reaches ready_o combinationally. Register 0 (address 0) selects the
// mode and reloads the accumulator with that mode's identity.
module float_sum_max_reduction_top import fsmr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire logic [31:0] value_bits_i,
  input  wire logic        is_last_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic      [31:0] result_bits_o
);

  mode_e       mode_q;
  logic [31:0] acc_q, acc_d, sum, res_q, skd_q;
  logic        vld_q, skd_vld_q, take, push, drain, cfg_wr;

  fsmr_add u_add (.a_i(acc_q), .b_i(value_bits_i), .sum_o(sum));

  assign pready  = 1'b1;
  assign prdata  = {31'd0, mode_q};
  assign cfg_wr  = psel && penable && pwrite && paddr[1:0] == {RegReduceMode, 1'b0};
  assign ready_o = !skd_vld_q;
  assign take    = valid_i && ready_o;
  assign push    = take && is_last_i;
  assign drain   = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign result_bits_o = res_q;

  always_comb begin
    if (mode_q == ModeMax) acc_d = f32_greater(value_bits_i, acc_q) ? value_bits_i : acc_q;
    else acc_d = sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeSum;
      acc_q     <= F32PosZero;
      vld_q     <= 1'b0;
      skd_vld_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        mode_q <= mode_e'(pwdata[0]);
        acc_q  <= identity_for(mode_e'(pwdata[0]));
      end else if (take) begin
        acc_q <= is_last_i ? identity_for(mode_q) : acc_d;
      end
      // The skid register only fills while the output register is stalled.
      if (drain) begin
        vld_q     <= skd_vld_q || push;
        skd_vld_q <= 1'b0;
      end else if (push) begin
        skd_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain) begin
      if (skd_vld_q) res_q <= skd_q;
      else if (push) res_q <= acc_d;
    end else if (push) begin
      skd_q <= acc_d;
    end
  end

endmodule
`default_nettype wire

>>> design/fsmr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "float_sum_max_reduction_top_macros.svh"
module fsmr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        valid_i,
  input wire logic        ready_o,
  input wire logic        is_last_i,
  input wire logic        valid_o,
  input wire logic        ready_i,
  input wire logic [31:0] result_bits_o
);
  // After a last item is taken, a result is always valid in the next cycle.
  `FSMR_ASSERT_NEXT(a_last_gives_result, clk_i, rst_ni, valid_i && ready_o && is_last_i, valid_o, "missing result")
  // Without a last item, an open input stays open.
  `FSMR_ASSERT_NEXT(a_no_spurious_stall, clk_i, rst_ni, ready_o && !(valid_i && is_last_i), ready_o, "input stalled without a result")
  // The input is open whenever no result is pending.
  `FSMR_ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !valid_o, ready_o, "input stalled while empty")
  // A stalled result holds its value.
  `FSMR_ASSERT_NEXT(a_hold, clk_i, rst_ni, valid_o && !ready_i, $stable(result_bits_o), "result changed while stalled")
endmodule

bind float_sum_max_reduction_top fsmr_checker u_fsmr_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .ready_o(ready_o),
  .is_last_i(is_last_i), .valid_o(valid_o), .ready_i(ready_i),
  .result_bits_o(result_bits_o)
);
`default_nettype wire
